FILE: rtl/assert_macros.svh
// Assertion macros shared by the keypoint median RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks an implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Checks a same-cycle implication.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/ktm_pkg.sv
// Package for the keypoint temporal median: sizes and payload types.
// No dependencies.
package ktm_pkg;
    localparam int WindowFrames  = 5;
    localparam int KeypointCount = 21;
    localparam int CoordBits     = 16;
    localparam int IdxBits       = 5;
    localparam int SlotBits      = (WindowFrames > 1) ? $clog2(WindowFrames) : 1;
    localparam int KpBits        = (KeypointCount > 1) ? $clog2(KeypointCount) : 1;
    localparam int MedRank       = WindowFrames / 2;
    localparam int RankBits      = $clog2(WindowFrames + 1);

    typedef logic signed [CoordBits-1:0] coord_t;
    typedef coord_t [2:0] point_t;
    typedef coord_t [WindowFrames-1:0] column_t;

    typedef struct packed {
        logic [IdxBits-1:0]   keypoint_index;
        coord_t               coord_x;
        coord_t               coord_y;
        coord_t               coord_z;
    } kp_in_t;

    typedef struct packed {
        logic [IdxBits-1:0]   out_index;
        coord_t               median_x;
        coord_t               median_y;
        coord_t               median_z;
        logic                 frame_last;
        logic                 frame_changed;
    } kp_out_t;

    // Per-stage sideband that travels with each transaction.
    typedef struct packed {
        logic              valid;
        logic [KpBits-1:0] kp;
        logic              last;
    } stage_ctl_t;
endpackage

FILE: rtl/ktm_window.sv
// Window store: one memory per frame slot, written and read in the same cycle,
// with same-address forwarding. Depends on ktm_pkg.
module ktm_window (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   wr_en,
    input  logic [ktm_pkg::KpBits-1:0] wr_kp,
    input  ktm_pkg::point_t        wr_point,
    input  logic                   frame_end,
    output ktm_pkg::point_t [ktm_pkg::WindowFrames-1:0] rd_points
);
    import ktm_pkg::*;

    localparam int Valids = WindowFrames * KeypointCount;

    point_t mem [WindowFrames][KeypointCount];
    logic [Valids-1:0] written_reg, written_next;
    logic [SlotBits-1:0] slot_reg, slot_next;
    point_t [WindowFrames-1:0] rd_raw_reg;
    logic [WindowFrames-1:0] rd_ok_reg;
    logic [WindowFrames-1:0] wr_hit;

    always_comb
    begin
        slot_next = slot_reg;
        written_next = written_reg;
        if (adv && wr_en)
        begin
            written_next[32'(slot_reg) * KeypointCount + 32'(wr_kp)] = 1'b1;
            if (frame_end)
            begin
                slot_next = (32'(slot_reg) + 1 >= WindowFrames) ? '0 : slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            written_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            written_reg <= written_next;
        end
    end

    always_comb
    begin
        for (int s = 0; s < WindowFrames; s++)
        begin
            wr_hit[s] = wr_en && (32'(slot_reg) == s);
        end
    end

    // Each slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (adv && wr_en)
        begin
            for (int s = 0; s < WindowFrames; s++)
            begin
                if (wr_hit[s])
                begin
                    mem[s][wr_kp] <= wr_point;
                    rd_raw_reg[s] <= wr_point;
                end
                else
                begin
                    rd_raw_reg[s] <= mem[s][wr_kp];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= '0;
        end
        else if (adv && wr_en)
        begin
            for (int s = 0; s < WindowFrames; s++)
            begin
                rd_ok_reg[s] <= wr_hit[s] ||
                    written_reg[s * KeypointCount + 32'(wr_kp)];
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < WindowFrames; s++)
        begin
            rd_points[s] = rd_ok_reg[s] ? rd_raw_reg[s] : '0;
        end
    end
endmodule

FILE: rtl/ktm_rank.sv
// Rank-select median of one coordinate column, split over two register
// stages: pairwise compares, then rank count and select. Depends on ktm_pkg.
module ktm_rank (
    input  logic                clk,
    input  logic                adv,
    input  ktm_pkg::column_t    column,
    output ktm_pkg::coord_t     median
);
    import ktm_pkg::*;

    localparam int N = WindowFrames;

    logic [N-1:0][N-1:0] lt_reg, eq_reg;
    column_t col_reg;
    coord_t median_reg, median_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_reg <= column;
            for (int a = 0; a < N; a++)
            begin
                for (int b = 0; b < N; b++)
                begin
                    lt_reg[a][b] <= column[b] < column[a];
                    eq_reg[a][b] <= column[b] == column[a];
                end
            end
        end
    end

    // Lowest candidate whose rank window covers the median rank wins.
    always_comb
    begin
        logic [RankBits-1:0] less, equal;
        median_next = '0;
        for (int a = N - 1; a >= 0; a--)
        begin
            less = '0;
            equal = '0;
            for (int b = 0; b < N; b++)
            begin
                less = less + RankBits'(lt_reg[a][b]);
                equal = equal + RankBits'(eq_reg[a][b] && !lt_reg[a][b]);
            end
            if (32'(less) <= MedRank && MedRank < 32'(less) + 32'(equal))
            begin
                median_next = col_reg[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            median_reg <= median_next;
        end
    end

    assign median = median_reg;
endmodule

FILE: rtl/ktm_change.sv
// Change tracker: previous medians per keypoint and the per-frame change
// flag. Depends on ktm_pkg.
module ktm_change (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  ktm_pkg::stage_ctl_t ctl,
    input  ktm_pkg::point_t     med,
    output logic                changed
);
    import ktm_pkg::*;
    `include "assert_macros.svh"

    point_t prev_reg [KeypointCount];
    logic [KeypointCount-1:0] prev_ok_reg;
    logic seen_reg, seen_next;
    point_t prev_val;
    logic diff;

    always_comb
    begin
        prev_val = prev_ok_reg[ctl.kp] ? prev_reg[ctl.kp] : '0;
        diff = prev_val != med;
        seen_next = seen_reg;
        changed = 1'b0;
        if (ctl.valid)
        begin
            changed = ctl.last && (seen_reg || diff);
            seen_next = ctl.last ? 1'b0 : (seen_reg || diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctl.valid)
        begin
            prev_reg[ctl.kp] <= med;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ok_reg <= '0;
            seen_reg <= 1'b0;
        end
        else if (adv)
        begin
            seen_reg <= seen_next;
            if (ctl.valid)
            begin
                prev_ok_reg[ctl.kp] <= 1'b1;
            end
        end
    end

    `ASSERT_NOW(a_changed_only_last, clk, rst_n, changed, ctl.last && ctl.valid)
    `ASSERT_NEXT(a_seen_clears, clk, rst_n, adv && ctl.valid && ctl.last, !seen_reg)
endmodule

FILE: rtl/keypoint_temporal_median.sv
// Keypoint temporal median filter, streaming one keypoint per cycle while no result stalls.
// Four register stages lie between an accepted input and its result.
// Throughput 1 per cycle; the whole pipe holds while a result stalls.
// Stages: window read, pairwise compare, rank select, change check + output.
// Reset marks window and previous medians empty and clears slot pointer and change flag at once.
// Depends on ktm_pkg and ktm_window, ktm_rank, ktm_change.
module keypoint_temporal_median (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ktm_pkg::kp_in_t  in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output ktm_pkg::kp_out_t out_data
);
    import ktm_pkg::*;
    `include "assert_macros.svh"

    logic adv, in_ok, in_take;
    stage_ctl_t ctl0, ctl1_reg, ctl2_reg, ctl3_reg;
    point_t in_point, med;
    point_t [WindowFrames-1:0] rd_points;
    column_t [2:0] cols;
    kp_out_t out_reg, out_next;
    logic out_vld_reg, changed;

    // The whole pipe moves unless a finished result is held back.
    assign adv = !(out_vld_reg && out_stall);
    assign in_stall = !adv;
    assign in_ok = 32'(in_data.keypoint_index) < KeypointCount;
    assign in_take = in_valid && in_ok;
    assign in_point = {CoordBits'(in_data.coord_x), CoordBits'(in_data.coord_y),
                       CoordBits'(in_data.coord_z)};

    always_comb
    begin
        ctl0.valid = in_take;
        ctl0.kp = KpBits'(in_data.keypoint_index);
        ctl0.last = 32'(in_data.keypoint_index) == KeypointCount - 1;
    end

    ktm_window u_window (
        .clk(clk), .rst_n(rst_n), .adv(adv), .wr_en(in_take),
        .wr_kp(ctl0.kp), .wr_point(in_point), .frame_end(ctl0.last),
        .rd_points(rd_points)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_coord
        for (genvar s = 0; s < WindowFrames; s++)
        begin : g_col
            assign cols[c][s] = rd_points[s][c];
        end
        ktm_rank u_rank (.clk(clk), .adv(adv), .column(cols[c]), .median(med[c]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctl1_reg <= ctl0;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            out_vld_reg <= ctl3_reg.valid;
        end
    end

    ktm_change u_change (
        .clk(clk), .rst_n(rst_n), .adv(adv), .ctl(ctl3_reg), .med(med),
        .changed(changed)
    );

    always_comb
    begin
        out_next.out_index = IdxBits'(ctl3_reg.kp);
        out_next.median_x = med[2];
        out_next.median_y = med[1];
        out_next.median_z = med[0];
        out_next.frame_last = ctl3_reg.last;
        out_next.frame_changed = changed;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data = out_reg;

    `ASSERT_NEXT(a_hold, clk, rst_n, out_vld_reg && out_stall, out_vld_reg && $stable(out_reg))
    `ASSERT_NOW(a_flag_last, clk, rst_n, out_vld_reg && out_reg.frame_changed, out_reg.frame_last)
endmodule

FILE: dv/tb.sv
// Testbench for keypoint_temporal_median: random and directed keypoint streams.
// A scoreboard class predicts each median and frame-change flag from its own window copy.
// Depends on ktm_pkg and the keypoint_temporal_median RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ktm_pkg::*;

    localparam int WatchdogLimit = 20000;

    class median_scoreboard;
        coord_t  window[WindowFrames][KeypointCount][3];
        coord_t  prev_med[KeypointCount][3];
        int      slot;
        bit      changed;
        kp_out_t pending[$];
        int      errors;

        function new();
            foreach (window[s, k, c]) window[s][k][c] = '0;
            foreach (prev_med[k, c]) prev_med[k][c] = '0;
            slot = 0;
            changed = 0;
            errors = 0;
        endfunction

        function coord_t rank_select(int kp, int c);
            int less;
            int equal;
            coord_t v;
            for (int a = 0; a < WindowFrames; a++)
            begin
                v = window[a][kp][c];
                less = 0;
                equal = 0;
                for (int b = 0; b < WindowFrames; b++)
                begin
                    if (window[b][kp][c] < v) less++;
                    else if (window[b][kp][c] == v) equal++;
                end
                if (less <= MedRank && MedRank < less + equal) return v;
            end
            return '0;
        endfunction

        function void note_keypoint(kp_in_t t);
            kp_out_t r;
            coord_t  m[3];
            bit      diff;
            int      kp;
            diff = 0;
            if (t.keypoint_index >= KeypointCount) return;
            kp = t.keypoint_index;
            window[slot][kp][0] = t.coord_x;
            window[slot][kp][1] = t.coord_y;
            window[slot][kp][2] = t.coord_z;
            for (int c = 0; c < 3; c++)
            begin
                m[c] = rank_select(kp, c);
                if (m[c] != prev_med[kp][c]) diff = 1;
                prev_med[kp][c] = m[c];
            end
            changed = changed || diff;
            r.out_index = t.keypoint_index;
            r.median_x = m[0];
            r.median_y = m[1];
            r.median_z = m[2];
            r.frame_last = (kp == KeypointCount - 1);
            r.frame_changed = r.frame_last && changed;
            if (r.frame_last)
            begin
                changed = 0;
                slot = (slot + 1 >= WindowFrames) ? 0 : slot + 1;
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_median(kp_out_t a);
            kp_out_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction, index %0d", a.out_index);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.out_index != e.out_index)
            begin
                $error("out_index: expected %0d, actual %0d", e.out_index, a.out_index);
                errors++;
            end
            if (a.median_x != e.median_x)
            begin
                $error("median_x: expected %0d, actual %0d", e.median_x, a.median_x);
                errors++;
            end
            if (a.median_y != e.median_y)
            begin
                $error("median_y: expected %0d, actual %0d", e.median_y, a.median_y);
                errors++;
            end
            if (a.median_z != e.median_z)
            begin
                $error("median_z: expected %0d, actual %0d", e.median_z, a.median_z);
                errors++;
            end
            if (a.frame_last != e.frame_last)
            begin
                $error("frame_last: expected %0d, actual %0d", e.frame_last, a.frame_last);
                errors++;
            end
            if (a.frame_changed != e.frame_changed)
            begin
                $error("frame_changed: expected %0d, actual %0d",
                       e.frame_changed, a.frame_changed);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    kp_in_t  in_data;
    logic    out_valid;
    logic    out_stall;
    kp_out_t out_data;

    median_scoreboard sb;
    bit quiet_phase;
    bit hold_receiver;
    int idle_cycles;

    keypoint_temporal_median uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Check results and watch for a stuck pipeline at each rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall) sb.check_median(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver stall pattern, with a long hold-off when requested.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                for (n = 0; n < 200; n++) @(negedge clk);
                hold_receiver = 0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= !quiet_phase && ($urandom_range(99) < 22);
        end
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return coord_t'($urandom_range(15)) - 16'sd8;
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_keypoint(logic [IdxBits-1:0] idx, coord_t x, coord_t y, coord_t z);
        kp_in_t t;
        t.keypoint_index = idx;
        t.coord_x = x;
        t.coord_y = y;
        t.coord_z = z;
        while (!quiet_phase && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        // Hold until the transaction is taken at a rising edge.
        do @(posedge clk); while (in_stall);
        sb.note_keypoint(t);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    task automatic send_frame(bit broken);
        for (int k = 0; k < KeypointCount; k++)
        begin
            if (broken && $urandom_range(3) == 0)
                send_keypoint(5'($urandom_range(31)), pick_coord(), pick_coord(),
                              pick_coord());
            else
                send_keypoint(5'(k), pick_coord(), pick_coord(), pick_coord());
        end
    endtask

    initial
    begin
        int sent;
        sb = new();
        quiet_phase = 0;
        hold_receiver = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, out-of-range and repeated indices, unchanged frame.
        send_keypoint(5'd0, 16'sh7fff, 16'sh8000, 16'sh0000);
        send_keypoint(5'd0, 16'sh8000, 16'sh7fff, 16'shffff);
        send_keypoint(5'd21, 16'sh1234, 16'sh1234, 16'sh1234);
        send_keypoint(5'd31, 16'shffff, 16'shffff, 16'shffff);
        send_keypoint(5'd7, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_keypoint(5'd20, 16'sh0000, 16'sh0000, 16'sh0000);
        send_keypoint(5'd20, 16'sh0000, 16'sh0000, 16'sh0000);
        send_keypoint(5'd3, 16'sh8000, 16'sh8000, 16'sh8000);
        send_keypoint(5'd20, 16'sh7fff, 16'sh8000, 16'sh5555);
        for (int f = 0; f < 6; f++)
            send_keypoint(5'd20, 16'sh7fff, 16'sh8000, 16'shaaaa);
        drain();

        // Receiver blocks for a long stretch while the sender keeps offering.
        hold_receiver = 1;
        send_frame(0);
        drain();

        sent = 0;
        while (sent < 600)
        begin
            quiet_phase = (sent >= 200 && sent < 300);
            send_frame($urandom_range(9) == 0);
            sent += KeypointCount;
        end
        quiet_phase = 0;
        drain();
        repeat (20) @(negedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/ktm_pkg.sv
rtl/ktm_window.sv
rtl/ktm_rank.sv
rtl/ktm_change.sv
rtl/keypoint_temporal_median.sv
dv/tb.sv
